[rtl/core/tabs_pkg.sv]
// ----------------------------------------------------------------------------
// tabs_pkg: shared definitions for the two-axis belt stepper sequencer
// Widths, timing constants, command codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package tabs_pkg;

  localparam int unsigned RATE_SCALE       = 500000;
  localparam int unsigned HOME_HALF_PERIOD = 100;

  localparam int HP_W   = 19;
  localparam int POS_W  = 32;
  localparam int TGT_W  = 15;
  localparam int FEED_W = 16;
  localparam int SPU_W  = 16;
  localparam int CMD_W  = 3;
  localparam int DIV_W  = FEED_W + SPU_W;
  localparam int DCNT_W = $clog2(HP_W);
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_STEPS_PER_UNIT = IDX_W'(0);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_MOVE     = 3'd1,
    CMD_HOME_ONE = 3'd2,
    CMD_HOME_TWO = 3'd3,
    CMD_DISABLE  = 3'd4
  } tabs_cmd_t;

  typedef struct packed {
    logic clear_phase;
    logic load_move;
    logic load_home_one;
    logic load_home_two;
    logic set_disable;
    logic start_pulse;
    logic run_pulse;
    logic step_one;
    logic step_two;
    logic dirs_one;
    logic dirs_two;
    logic zero_one;
    logic zero_two;
  } tabs_ctrl_t;

  typedef struct packed {
    logic boundary;
    logic at_goal_one;
    logic at_goal_two;
    logic div_busy;
  } tabs_stat_t;

endpackage

[rtl/core/tabs_div.sv]
// ----------------------------------------------------------------------------
// tabs_div: half period divider
// Restoring division of the rate scale by a 32-bit divisor, one quotient
// bit per cycle; a zero divisor counts as one and a zero quotient as one.
// ----------------------------------------------------------------------------
module tabs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tabs_pkg::DIV_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [tabs_pkg::HP_W-1:0]   quotient
);
  import tabs_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  den_r, den_nxt;
  logic [HP_W-1:0]   num_r, num_nxt;
  logic [HP_W-1:0]   rem_r, rem_nxt;
  logic [HP_W-1:0]   quo_r, quo_nxt;
  logic [HP_W:0]     rem_sh;
  logic [DIV_W-1:0]  diff;
  logic              fits;

  always_comb begin
    rem_sh   = {rem_r, num_r[HP_W-1]};
    fits     = DIV_W'(rem_sh) >= den_r;
    diff     = DIV_W'(rem_sh) - den_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(HP_W - 1);
      den_nxt  = (divisor == '0) ? DIV_W'(1) : divisor;
      num_nxt  = HP_W'(RATE_SCALE);
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[HP_W-2:0], 1'b0};
      rem_nxt = fits ? diff[HP_W-1:0] : rem_sh[HP_W-1:0];
      quo_nxt = {quo_r[HP_W-2:0], fits};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r | done_r;
  assign done     = done_r;
  assign quotient = (quo_r == '0) ? HP_W'(1) : quo_r;

endmodule

[rtl/core/tabs_dp.sv]
// ----------------------------------------------------------------------------
// tabs_dp: sequencer datapath
// Positions, goals, step timing counter, direction and enable lines, the
// steps-per-unit register and the half period divider.
// ----------------------------------------------------------------------------
module tabs_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tabs_pkg::tabs_ctrl_t              ctrl,
  output tabs_pkg::tabs_stat_t              stat,
  input  logic [tabs_pkg::TGT_W-1:0]        target_one,
  input  logic [tabs_pkg::TGT_W-1:0]        target_two,
  input  logic [tabs_pkg::FEED_W-1:0]       feed_rate,
  input  logic                              cfg_we,
  input  logic [tabs_pkg::SPU_W-1:0]        cfg_wdata,
  output logic [tabs_pkg::SPU_W-1:0]        steps_per_unit,
  output logic                              enable_n,
  output logic                              dir_a,
  output logic                              dir_b,
  output logic                              step_pulse,
  output logic signed [tabs_pkg::POS_W-1:0] position_one,
  output logic signed [tabs_pkg::POS_W-1:0] position_two
);
  import tabs_pkg::*;

  logic [SPU_W-1:0]        spu_r;
  logic signed [POS_W-1:0] pos1_r, pos1_nxt, pos2_r, pos2_nxt;
  logic signed [POS_W-1:0] goal1_r, goal1_nxt, goal2_r, goal2_nxt;
  logic [HP_W-1:0]         hp_r, hp_nxt, tc_r, tc_nxt;
  logic                    cl_r, cl_nxt, en_r, en_nxt;
  logic [1:0]              dir_r, dir_nxt;

  logic [HP_W-1:0]         h, tc0, tc1;
  logic                    cl0, cl1, pend, step_end;
  logic                    lt1, gt1, lt2, neg1, posv1, neg2;
  logic [TGT_W+SPU_W-1:0]  prod1, prod2;
  logic [FEED_W-1:0]       feed_eff;
  logic [DIV_W-1:0]        dprod;
  logic                    div_busy, div_done;
  logic [HP_W-1:0]         div_q;

  tabs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.load_move),
    .divisor  (dprod),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    h     = (hp_r == '0) ? HP_W'(1) : hp_r;
    cl0   = ctrl.start_pulse | cl_r;
    tc0   = ctrl.start_pulse ? HP_W'(1) : tc_r;
    if (cl0) begin
      if (tc0 >= h) begin
        cl1 = 1'b0;
        tc1 = HP_W'(1);
      end else begin
        cl1 = 1'b1;
        tc1 = tc0 + HP_W'(1);
      end
    end else begin
      cl1 = 1'b0;
      tc1 = tc0 + HP_W'(1);
    end
    pend     = !cl1 && (tc1 >= h);
    step_end = ctrl.run_pulse && pend;

    lt1   = pos1_r < goal1_r;
    gt1   = pos1_r > goal1_r;
    lt2   = pos2_r < goal2_r;
    neg1  = pos1_r < 0;
    posv1 = pos1_r > 0;
    neg2  = pos2_r < 0;

    prod1    = target_one * spu_r;
    prod2    = target_two * spu_r;
    feed_eff = (feed_rate == '0) ? FEED_W'(1) : feed_rate;
    dprod    = feed_eff * spu_r;

    tc_nxt    = tc_r;
    cl_nxt    = cl_r;
    pos1_nxt  = pos1_r;
    pos2_nxt  = pos2_r;
    goal1_nxt = goal1_r;
    goal2_nxt = goal2_r;
    hp_nxt    = hp_r;
    en_nxt    = en_r;
    dir_nxt   = dir_r;

    if (ctrl.clear_phase) begin
      tc_nxt = '0;
      cl_nxt = 1'b0;
    end else if (ctrl.run_pulse) begin
      cl_nxt = cl1;
      tc_nxt = pend ? '0 : tc1;
    end

    if (ctrl.zero_one) begin
      pos1_nxt = '0;
    end else if (ctrl.step_one && step_end) begin
      if (lt1) begin
        pos1_nxt = pos1_r + POS_W'(1);
      end else if (gt1) begin
        pos1_nxt = pos1_r - POS_W'(1);
      end
    end

    if (ctrl.zero_two) begin
      pos2_nxt = '0;
    end else if (ctrl.step_two && step_end) begin
      if (lt2) begin
        pos2_nxt = pos2_r + POS_W'(1);
      end else if (pos2_r > goal2_r) begin
        pos2_nxt = pos2_r - POS_W'(1);
      end
    end

    if (ctrl.load_move) begin
      goal1_nxt = $signed(POS_W'(prod1));
      goal2_nxt = $signed(POS_W'(prod2));
      en_nxt    = 1'b0;
    end
    if (ctrl.load_home_one) begin
      goal1_nxt = '0;
      hp_nxt    = HP_W'(HOME_HALF_PERIOD);
      if (neg1) begin
        dir_nxt = 2'b01;
      end else if (posv1) begin
        dir_nxt = 2'b10;
      end else begin
        dir_nxt = {1'b0, dir_r[0]};
      end
    end
    if (ctrl.load_home_two) begin
      goal2_nxt = '0;
      hp_nxt    = HP_W'(HOME_HALF_PERIOD);
      dir_nxt   = neg2 ? 2'b00 : 2'b11;
    end
    if (ctrl.set_disable) begin
      en_nxt = 1'b1;
    end
    if (div_done) begin
      hp_nxt = div_q;
    end
    if (ctrl.dirs_one) begin
      if (lt1) begin
        dir_nxt = 2'b01;
      end else if (gt1) begin
        dir_nxt = 2'b10;
      end else begin
        dir_nxt = {1'b0, dir_r[0]};
      end
    end
    if (ctrl.dirs_two) begin
      dir_nxt = lt2 ? 2'b00 : 2'b11;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spu_r   <= SPU_W'(1);
      pos1_r  <= '0;
      pos2_r  <= '0;
      goal1_r <= '0;
      goal2_r <= '0;
      hp_r    <= '0;
      tc_r    <= '0;
      cl_r    <= 1'b0;
      dir_r   <= '0;
      en_r    <= 1'b1;
    end else begin
      if (cfg_we) begin
        spu_r <= cfg_wdata;
      end
      pos1_r  <= pos1_nxt;
      pos2_r  <= pos2_nxt;
      goal1_r <= goal1_nxt;
      goal2_r <= goal2_nxt;
      hp_r    <= hp_nxt;
      tc_r    <= tc_nxt;
      cl_r    <= cl_nxt;
      dir_r   <= dir_nxt;
      en_r    <= en_nxt;
    end
  end

  assign stat.boundary    = !cl_r && (tc_r == '0);
  assign stat.at_goal_one = pos1_r == goal1_r;
  assign stat.at_goal_two = pos2_r == goal2_r;
  assign stat.div_busy    = div_busy;

  assign steps_per_unit = spu_r;
  assign enable_n       = en_r;
  assign dir_a          = dir_r[0];
  assign dir_b          = dir_r[1];
  assign step_pulse     = cl_r;
  assign position_one   = pos1_r;
  assign position_two   = pos2_r;

endmodule

[rtl/core/tabs_ctrl.sv]
// ----------------------------------------------------------------------------
// tabs_ctrl: sequencer controller
// Request handshake, command decode and the move/homing state machine.
// ----------------------------------------------------------------------------
module tabs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tabs_pkg::CMD_W-1:0]   in_cmd,
  input  logic                         switch_one,
  input  logic                         switch_two,
  output logic                         out_valid,
  input  logic                         out_stall,
  input  tabs_pkg::tabs_stat_t         stat,
  output tabs_pkg::tabs_ctrl_t         ctrl,
  output logic                         busy
);
  import tabs_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_AXIS_ONE,
    M_AXIS_TWO,
    M_HOME_ONE,
    M_HOME_TWO
  } mode_t;

  mode_t      mode_r, mode_nxt, axis;
  logic       busy_r, out_valid_r, out_valid_nxt;
  logic       tick, sw, fin;
  tabs_ctrl_t c;

  assign in_stall      = stat.div_busy || (out_valid_r && out_stall);
  assign tick          = in_valid && !in_stall;
  assign out_valid_nxt = tick || (out_valid_r && out_stall);

  always_comb begin
    c        = '0;
    mode_nxt = mode_r;
    axis     = mode_r;
    fin      = 1'b0;
    sw       = (mode_r == M_HOME_ONE) ? switch_one : switch_two;
    if (tick) begin
      case (mode_r)
        M_IDLE: begin
          c.clear_phase = 1'b1;
          case (tabs_cmd_t'(in_cmd))
            CMD_MOVE: begin
              c.load_move = 1'b1;
              mode_nxt    = M_AXIS_ONE;
            end
            CMD_HOME_ONE: begin
              c.load_home_one = 1'b1;
              mode_nxt        = M_HOME_ONE;
            end
            CMD_HOME_TWO: begin
              c.load_home_two = 1'b1;
              mode_nxt        = M_HOME_TWO;
            end
            CMD_DISABLE: begin
              c.set_disable = 1'b1;
            end
            default: begin
            end
          endcase
        end
        M_AXIS_ONE, M_AXIS_TWO: begin
          if (stat.boundary) begin
            if (mode_r == M_AXIS_ONE && stat.at_goal_one) begin
              axis = M_AXIS_TWO;
            end
            if (axis == M_AXIS_TWO && stat.at_goal_two) begin
              fin = 1'b1;
            end else begin
              c.start_pulse = 1'b1;
              c.dirs_one    = (axis == M_AXIS_ONE);
              c.dirs_two    = (axis == M_AXIS_TWO);
            end
          end
          if (fin) begin
            mode_nxt = M_IDLE;
          end else begin
            mode_nxt    = axis;
            c.run_pulse = 1'b1;
            c.step_one  = (axis == M_AXIS_ONE);
            c.step_two  = (axis == M_AXIS_TWO);
          end
        end
        M_HOME_ONE, M_HOME_TWO: begin
          if (stat.boundary && !sw) begin
            c.zero_one = (mode_r == M_HOME_ONE);
            c.zero_two = (mode_r == M_HOME_TWO);
            mode_nxt   = M_IDLE;
          end else begin
            c.start_pulse = stat.boundary;
            c.run_pulse   = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      busy_r      <= (mode_nxt != M_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign ctrl      = c;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

[rtl/core/two_axis_belt_stepper_sequencer.sv]
// ----------------------------------------------------------------------------
// two_axis_belt_stepper_sequencer: two-axis belt stepper step generator
// Each request on the input channel is one time-base tick, optionally with
// a command (move, home axis 1, home axis 2, disable) and the home switch
// levels. Every request produces one result: driver enable, the two
// direction lines, the shared step clock, the busy flag and both positions
// as they stand after that tick.
// A result is registered and offered in the cycle after its request is
// taken; one request is taken per cycle while the result side keeps up
// and no move division is running. A move request starts the half period
// divider, which finds one quotient bit per cycle; the input stalls after
// a move is taken until the quotient is loaded. When the result side stalls,
// the pending result holds and the input stalls as well, so no tick is lost.
// Reset clears positions and goals, leaves the sequencer idle with the
// drivers disabled and sets steps_per_unit to 1. The register port is to be
// written only while the sequencer is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module two_axis_belt_stepper_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tabs_pkg::CMD_W-1:0]        in_cmd,
  input  logic [tabs_pkg::TGT_W-1:0]        in_target_one,
  input  logic [tabs_pkg::TGT_W-1:0]        in_target_two,
  input  logic [tabs_pkg::FEED_W-1:0]       in_feed_rate,
  input  logic                              in_switch_one,
  input  logic                              in_switch_two,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_enable_n,
  output logic                              out_dir_a,
  output logic                              out_dir_b,
  output logic                              out_step_pulse,
  output logic                              out_busy_res,
  output logic signed [tabs_pkg::POS_W-1:0] out_position_one,
  output logic signed [tabs_pkg::POS_W-1:0] out_position_two,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tabs_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [tabs_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [tabs_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import tabs_pkg::*;

  tabs_ctrl_t       ctrl;
  tabs_stat_t       stat;
  logic             cfg_we;
  logic             cfg_hit;
  logic [SPU_W-1:0] spu;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[ADDR_W-1:2] == REG_STEPS_PER_UNIT);
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? DATA_W'(spu) : '0;

  tabs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .switch_one (in_switch_one),
    .switch_two (in_switch_two),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .ctrl       (ctrl),
    .busy       (out_busy_res)
  );

  tabs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .target_one     (in_target_one),
    .target_two     (in_target_two),
    .feed_rate      (in_feed_rate),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_pwdata[SPU_W-1:0]),
    .steps_per_unit (spu),
    .enable_n       (out_enable_n),
    .dir_a          (out_dir_a),
    .dir_b          (out_dir_b),
    .step_pulse     (out_step_pulse),
    .position_one   (out_position_one),
    .position_two   (out_position_two)
  );

  a_enable_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_enable_n) |-> $past(in_valid && !in_stall))
    else $error("driver enable changed without a request");

  a_position_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_position_one) || !$stable(out_position_two) |->
      $past(in_valid && !in_stall))
    else $error("position changed without a request");

  a_idle_clock_low: assert property (@(posedge clk) disable iff (!rst_n)
    !out_busy_res |-> !out_step_pulse)
    else $error("step clock high while idle");

endmodule

[sim/two_axis_belt_stepper_sequencer_checker.sv]
// ----------------------------------------------------------------------------
// two_axis_belt_stepper_sequencer_checker: tick-by-tick status checker
// Watches the request, result and register channels of the sequencer. Each
// accepted request advances a private model of the sequencer by one tick and
// queues the status it should report. Each accepted result is compared field
// by field with the oldest queued status.
// ----------------------------------------------------------------------------
module two_axis_belt_stepper_sequencer_checker
  import tabs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [TGT_W-1:0]         in_target_one,
  input  logic [TGT_W-1:0]         in_target_two,
  input  logic [FEED_W-1:0]        in_feed_rate,
  input  logic                     in_switch_one,
  input  logic                     in_switch_two,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     out_enable_n,
  input  logic                     out_dir_a,
  input  logic                     out_dir_b,
  input  logic                     out_step_pulse,
  input  logic                     out_busy_res,
  input  logic signed [POS_W-1:0]  out_position_one,
  input  logic signed [POS_W-1:0]  out_position_two,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [ADDR_W-1:0]        cfg_paddr,
  input  logic [DATA_W-1:0]        cfg_pwdata,
  input  logic                     cfg_pready,
  output int                       fail_count,
  output int                       open_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_AXIS_ONE,
    SEQ_AXIS_TWO,
    SEQ_HOME_ONE,
    SEQ_HOME_TWO
  } seq_state_t;

  typedef struct packed {
    logic                    enable_n;
    logic                    dir_a;
    logic                    dir_b;
    logic                    step_pulse;
    logic                    busy;
    logic signed [POS_W-1:0] pos_one;
    logic signed [POS_W-1:0] pos_two;
  } status_t;

  logic [SPU_W-1:0]        steps_unit;
  logic signed [POS_W-1:0] place_one;
  logic signed [POS_W-1:0] place_two;
  logic signed [POS_W-1:0] dest_one;
  logic signed [POS_W-1:0] dest_two;
  logic [HP_W-1:0]         half_ticks;
  logic [HP_W-1:0]         phase_ticks;
  seq_state_t              seq_state;
  logic                    clk_line;
  logic                    drv_off;
  logic [1:0]              dirs;
  status_t                 status_q[$];
  int                      result_idx;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%t: result %0d: %s", $realtime, result_idx, msg);
  endtask

  task automatic check_field(input string name, input logic signed [POS_W-1:0] want,
                             input logic signed [POS_W-1:0] got);
    if (got !== want) begin
      report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  function automatic void aim_axis_one();
    if (place_one < dest_one) begin
      dirs = 2'b01;
    end else if (place_one > dest_one) begin
      dirs = 2'b10;
    end else begin
      dirs[1] = 1'b0;
    end
  endfunction

  function automatic void aim_axis_two();
    dirs = (place_two < dest_two) ? 2'b00 : 2'b11;
  endfunction

  function automatic logic signed [POS_W-1:0] nudge(input logic signed [POS_W-1:0] p,
                                                    input logic signed [POS_W-1:0] g);
    if (p < g) begin
      return p + 1;
    end else if (p > g) begin
      return p - 1;
    end
    return p;
  endfunction

  // Counts one tick of the current clock phase; true when a full step ends.
  function automatic logic advance_phase();
    logic [HP_W-1:0] span;
    span = (half_ticks != '0) ? half_ticks : HP_W'(1);
    if (clk_line) begin
      if (phase_ticks >= span) begin
        clk_line = 1'b0;
        phase_ticks = HP_W'(1);
      end else begin
        phase_ticks = phase_ticks + 1'b1;
      end
    end else begin
      phase_ticks = phase_ticks + 1'b1;
    end
    if (!clk_line && phase_ticks >= span) begin
      phase_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void take_command(input logic [CMD_W-1:0] code,
                                       input logic [TGT_W-1:0] t1, input logic [TGT_W-1:0] t2,
                                       input logic [FEED_W-1:0] feed);
    logic [63:0] rate_div;
    logic [63:0] span;
    case (code)
      CMD_MOVE: begin
        dest_one = 32'(t1) * 32'(steps_unit);
        dest_two = 32'(t2) * 32'(steps_unit);
        rate_div = 64'((feed == '0) ? FEED_W'(1) : feed) * 64'(steps_unit);
        if (rate_div == 0) begin
          rate_div = 64'd1;
        end
        span = 64'(RATE_SCALE) / rate_div;
        if (span == 0) begin
          span = 64'd1;
        end
        half_ticks = span[HP_W-1:0];
        drv_off = 1'b0;
        seq_state = SEQ_AXIS_ONE;
      end
      CMD_HOME_ONE: begin
        dest_one = '0;
        aim_axis_one();
        half_ticks = HP_W'(HOME_HALF_PERIOD);
        seq_state = SEQ_HOME_ONE;
      end
      CMD_HOME_TWO: begin
        dest_two = '0;
        aim_axis_two();
        half_ticks = HP_W'(HOME_HALF_PERIOD);
        seq_state = SEQ_HOME_TWO;
      end
      CMD_DISABLE: begin
        drv_off = 1'b1;
      end
      default: begin
      end
    endcase
    phase_ticks = '0;
    clk_line = 1'b0;
  endfunction

  function automatic void run_motion(input logic sw1, input logic sw2);
    logic at_boundary;
    at_boundary = !clk_line && phase_ticks == '0;
    if (seq_state == SEQ_AXIS_ONE || seq_state == SEQ_AXIS_TWO) begin
      if (at_boundary) begin
        if (seq_state == SEQ_AXIS_ONE && place_one == dest_one) begin
          seq_state = SEQ_AXIS_TWO;
        end
        if (seq_state == SEQ_AXIS_TWO && place_two == dest_two) begin
          seq_state = SEQ_IDLE;
          return;
        end
        if (seq_state == SEQ_AXIS_ONE) begin
          aim_axis_one();
        end else begin
          aim_axis_two();
        end
        clk_line = 1'b1;
        phase_ticks = HP_W'(1);
      end
      if (advance_phase()) begin
        if (seq_state == SEQ_AXIS_ONE) begin
          place_one = nudge(place_one, dest_one);
        end else begin
          place_two = nudge(place_two, dest_two);
        end
      end
    end else if (seq_state == SEQ_HOME_ONE || seq_state == SEQ_HOME_TWO) begin
      if (at_boundary) begin
        if (!((seq_state == SEQ_HOME_ONE) ? sw1 : sw2)) begin
          if (seq_state == SEQ_HOME_ONE) begin
            place_one = '0;
          end else begin
            place_two = '0;
          end
          seq_state = SEQ_IDLE;
          return;
        end
        clk_line = 1'b1;
        phase_ticks = HP_W'(1);
      end
      void'(advance_phase());
    end
  endfunction

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      steps_unit = SPU_W'(1);
      place_one = '0;
      place_two = '0;
      dest_one = '0;
      dest_two = '0;
      half_ticks = '0;
      phase_ticks = '0;
      seq_state = SEQ_IDLE;
      clk_line = 1'b0;
      drv_off = 1'b1;
      dirs = 2'b00;
      status_q.delete();
      result_idx = 0;
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[ADDR_W-1:2] == REG_STEPS_PER_UNIT) begin
        steps_unit = cfg_pwdata[SPU_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = status_q.pop_front();
          check_field("enable_n", POS_W'(want.enable_n), POS_W'(out_enable_n));
          check_field("dir_a", POS_W'(want.dir_a), POS_W'(out_dir_a));
          check_field("dir_b", POS_W'(want.dir_b), POS_W'(out_dir_b));
          check_field("step_pulse", POS_W'(want.step_pulse), POS_W'(out_step_pulse));
          check_field("busy_res", POS_W'(want.busy), POS_W'(out_busy_res));
          check_field("position_one", want.pos_one, out_position_one);
          check_field("position_two", want.pos_two, out_position_two);
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        if (seq_state == SEQ_IDLE) begin
          take_command(in_cmd, in_target_one, in_target_two, in_feed_rate);
        end else begin
          run_motion(in_switch_one, in_switch_two);
        end
        want.enable_n = drv_off;
        want.dir_a = dirs[0];
        want.dir_b = dirs[1];
        want.step_pulse = clk_line;
        want.busy = (seq_state != SEQ_IDLE);
        want.pos_one = place_one;
        want.pos_two = place_two;
        status_q.push_back(want);
      end
    end
    open_results = status_q.size();
  end

endmodule

[sim/two_axis_belt_stepper_sequencer_test.sv]
// ----------------------------------------------------------------------------
// two_axis_belt_stepper_sequencer_test: top-level testbench
// Drives tick requests and register writes into the sequencer: a directed
// pass over every command, homing with and without pulses, ignored codes
// and the steps_per_unit extremes, then three random phases with different
// scaling and handshake idling, one of them with a long result back-pressure.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module two_axis_belt_stepper_sequencer_test;
  import tabs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_DISABLE + 1'b1;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;
  localparam logic [IDX_W-1:0] REG_UNUSED   = REG_STEPS_PER_UNIT + 1'b1;
  localparam int               HOLD_CYCLES  = 300;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_cmd;
  logic [TGT_W-1:0]        in_target_one;
  logic [TGT_W-1:0]        in_target_two;
  logic [FEED_W-1:0]       in_feed_rate;
  logic                    in_switch_one;
  logic                    in_switch_two;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_enable_n;
  logic                    out_dir_a;
  logic                    out_dir_b;
  logic                    out_step_pulse;
  logic                    out_busy_res;
  logic signed [POS_W-1:0] out_position_one;
  logic signed [POS_W-1:0] out_position_two;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [ADDR_W-1:0]       cfg_paddr;
  logic [DATA_W-1:0]       cfg_pwdata;
  logic [DATA_W-1:0]       cfg_prdata;
  logic                    cfg_pready;

  int   fail_count;
  int   open_results;
  int   sent_reqs = 0;
  int   done_reqs = 0;
  logic last_busy = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   hold_left = 0;

  two_axis_belt_stepper_sequencer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_target_one    (in_target_one),
    .in_target_two    (in_target_two),
    .in_feed_rate     (in_feed_rate),
    .in_switch_one    (in_switch_one),
    .in_switch_two    (in_switch_two),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_enable_n     (out_enable_n),
    .out_dir_a        (out_dir_a),
    .out_dir_b        (out_dir_b),
    .out_step_pulse   (out_step_pulse),
    .out_busy_res     (out_busy_res),
    .out_position_one (out_position_one),
    .out_position_two (out_position_two),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  two_axis_belt_stepper_sequencer_checker status_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_target_one    (in_target_one),
    .in_target_two    (in_target_two),
    .in_feed_rate     (in_feed_rate),
    .in_switch_one    (in_switch_one),
    .in_switch_two    (in_switch_two),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_enable_n     (out_enable_n),
    .out_dir_a        (out_dir_a),
    .out_dir_b        (out_dir_b),
    .out_step_pulse   (out_step_pulse),
    .out_busy_res     (out_busy_res),
    .out_position_one (out_position_one),
    .out_position_two (out_position_two),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_pready       (cfg_pready),
    .fail_count       (fail_count),
    .open_results     (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      done_reqs <= done_reqs + 1;
      last_busy <= out_busy_res;
    end
  end

  initial begin
    #5ms;
    $display("FAIL two_axis_belt_stepper_sequencer");
    $finish;
  end

  task automatic send_req(input logic [CMD_W-1:0] code, input logic [TGT_W-1:0] t1,
                          input logic [TGT_W-1:0] t2, input logic [FEED_W-1:0] feed,
                          input logic s1, input logic s2);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= code;
    in_target_one <= t1;
    in_target_two <= t2;
    in_feed_rate  <= feed;
    in_switch_one <= s1;
    in_switch_two <= s2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_reqs++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (done_reqs != sent_reqs) @(posedge clk);
  endtask

  // Ticks the sequencer with open home switches until it reports idle.
  task automatic settle();
    wait_results();
    while (last_busy) begin
      send_req(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
      wait_results();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [SPU_W-1:0] spu, input int tgt_max, input int feed_lo,
                           input int count, input int tx_pct, input int rx_pct,
                           input bit hold);
    int               roll;
    logic [CMD_W-1:0] code;
    write_reg(REG_STEPS_PER_UNIT, DATA_W'(spu));
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (hold) begin
      hold_left <= HOLD_CYCLES;
    end
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        code = CMD_TICK;
      end else if (roll < 82) begin
        code = CMD_MOVE;
      end else if (roll < 88) begin
        code = CMD_HOME_ONE;
      end else if (roll < 94) begin
        code = CMD_HOME_TWO;
      end else if (roll < 98) begin
        code = CMD_DISABLE;
      end else begin
        code = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      send_req(code, TGT_W'($urandom_range(tgt_max)), TGT_W'($urandom_range(tgt_max)),
               FEED_W'($urandom_range(feed_lo, 65535)),
               $urandom_range(99) < 20, $urandom_range(99) < 20);
    end
    settle();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_TICK;
    in_target_one <= '0;
    in_target_two <= '0;
    in_feed_rate  <= '0;
    in_switch_one <= 1'b0;
    in_switch_two <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    tx_idle_pct = 11;
    rx_idle_pct = 59;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(CMD_TICK, '1, '1, '1, 1'b1, 1'b1);
    send_req(CMD_DISABLE, '0, '0, '0, 1'b0, 1'b0);
    send_req(CMD_MOVE, 2, 1, '1, 1'b0, 1'b0);
    settle();
    send_req(CMD_MOVE, 0, 3, 40000, 1'b0, 1'b0);
    settle();
    send_req(CMD_DISABLE, '0, '0, '0, 1'b0, 1'b0);
    send_req(CMD_HOME_TWO, '0, '0, '0, 1'b0, 1'b0);
    send_req(CMD_TICK, '0, '0, '0, 1'b0, 1'b1);
    settle();
    send_req(CMD_MOVE, 1, 0, '1, 1'b0, 1'b0);
    settle();
    send_req(CMD_HOME_ONE, '0, '0, '0, 1'b0, 1'b0);
    send_req(CMD_TICK, '0, '0, '0, 1'b1, 1'b0);
    settle();
    send_req(CMD_MOVE, 3, 2, '1, 1'b0, 1'b0);
    send_req(CMD_HOME_ONE, '0, '0, '0, 1'b1, 1'b1);
    send_req(CMD_MOVE, 0, 0, '1, 1'b0, 1'b0);
    settle();
    send_req(CMD_SPARE_LO, 1, 1, '1, 1'b0, 1'b0);
    send_req(CMD_SPARE_HI, 1, 1, '1, 1'b0, 1'b0);
    settle();
    write_reg(REG_UNUSED, 8);
    send_req(CMD_MOVE, 1, 1, '1, 1'b0, 1'b0);
    settle();
    send_req(CMD_HOME_ONE, '0, '0, '0, 1'b0, 1'b0);
    settle();
    send_req(CMD_HOME_TWO, '0, '0, '0, 1'b0, 1'b0);
    settle();
    write_reg(REG_STEPS_PER_UNIT, 0);
    send_req(CMD_MOVE, '1, '1, '0, 1'b0, 1'b0);
    settle();
    send_req(CMD_MOVE, 15'h2AAA, 15'h5555, 16'h5555, 1'b0, 1'b0);
    settle();
    write_reg(REG_STEPS_PER_UNIT, 65535);
    send_req(CMD_MOVE, '0, '0, '0, 1'b0, 1'b0);
    settle();

    run_phase(1, 3, 25000, 170, 11, 59, 1'b0);
    run_phase(8, 3, 16384, 170, 59, 11, 1'b0);
    run_phase(65535, 0, 0, 170, 0, 0, 1'b1);

    repeat (20) @(posedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("PASS two_axis_belt_stepper_sequencer");
    end else begin
      $display("FAIL two_axis_belt_stepper_sequencer");
    end
    $finish;
  end

endmodule
